// ----- hdl/ued_pkg.sv -----
`timescale 1ns / 1ps
// ued_pkg: shared types, character codes and hex helpers for the unicode escape decoder
// no dependencies

package ued_pkg;

   localparam int MAX_U_RUN_DEF = 8;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SLASH,
      PH_URUN,
      PH_DIGITS
   } phase_type;

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_nib(input logic [7:0] b);
      logic [3:0] r;
      if (b <= 8'h39) begin
         r = b[3:0];
      end else begin
         r = b[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

// ----- hdl/ued_req_if.sv -----
`timescale 1ns / 1ps
// ued_req_if: input channel of the unicode escape decoder, one raw byte per beat
// no dependencies

interface ued_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       line_end;

   modport source (output valid, output in_byte, output line_end, input ready);
   modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

// ----- hdl/ued_rsp_if.sv -----
`timescale 1ns / 1ps
// ued_rsp_if: result channel of the unicode escape decoder, one code unit per beat
// no dependencies

interface ued_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        from_escape;
   logic        ends_line;
   logic        last_of_run;

   modport source (output valid, output code_unit, output from_escape, output ends_line,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_unit, input from_escape, input ends_line,
                   input last_of_run, output ready);
endinterface

// ----- hdl/unicode_escape_decoder.sv -----
`timescale 1ns / 1ps
// unicode_escape_decoder: top level, decodes \uXXXX escapes in a raw source byte stream
// depends on ued_pkg, ued_req_if, ued_rsp_if
//
// Takes one source byte per req beat and gives 16-bit code units on rsp. An input
// byte is decoded in the cycle it is taken and leaves a short list of results
// (a replay of a failed escape, then one plain or decoded unit) in a job register;
// a single output register sends that list one beat per cycle while rsp is not
// stalled. A byte that gives zero or one result does not hold req, so plain text
// streams at one byte per cycle while rsp is not stalled; a byte that gives N
// results, N at most MAX_U_RUN + 5, holds req until its last result is loaded into
// the output register. A first rsp beat passes the job and then the output register.

module unicode_escape_decoder #(
   parameter int MAX_U_RUN = ued_pkg::MAX_U_RUN_DEF
) (
   input logic        clock,
   input logic        reset,
   ued_req_if.sink    req,
   ued_rsp_if.source  rsp
);
   import ued_pkg::*;

   localparam int UW = $clog2(MAX_U_RUN + 1);
   localparam int CW = $clog2(MAX_U_RUN + 5);

   // decoder state
   logic            odd_ff, odd_in;
   phase_type       phase_ff, phase_in;
   logic [UW-1:0]   ucnt_ff, ucnt_in;
   logic [1:0]      dcnt_ff, dcnt_in;
   logic [7:0]      held_ff [3];
   logic            wr_en;
   logic [1:0]      wr_idx;

   // pending job
   logic            job_vld_ff;
   logic            job_rep_ff;
   logic [UW-1:0]   job_u_ff;
   logic [1:0]      job_d_ff;
   logic [7:0]      job_dig_ff [3];
   logic [15:0]     job_val_ff;
   logic            job_esc_ff;
   logic            job_le_ff;
   logic [CW-1:0]   job_last_ff;
   logic [CW-1:0]   idx_ff;

   // output register
   logic            rsp_vld_ff;
   logic [15:0]     rsp_unit_ff;
   logic            rsp_esc_ff;
   logic            rsp_le_ff;
   logic            rsp_last_ff;

   logic [7:0]      b;
   logic            le, hx, is_u, is_bs;
   logic            fail, esc_done, adv, plain, odd_mid, open_esc, tail_any;
   logic [15:0]     new_val;
   logic [CW-1:0]   new_cnt, new_last;
   logic            req_acc, out_load, item_last;
   logic [CW-1:0]   off;
   logic [15:0]     item_unit;
   logic            item_esc;

   assign b     = req.in_byte;
   assign le    = req.line_end;
   assign hx    = is_hex(b);
   assign is_u  = (b == CH_U);
   assign is_bs = (b == CH_BACKSLASH);

   // classify the byte against the pending escape
   always_comb begin
      fail     = 1'b0;
      esc_done = 1'b0;
      adv      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
         end
         PH_SLASH: begin
            if (is_u && !le) adv = 1'b1;
            else             fail = 1'b1;
         end
         PH_URUN: begin
            if ((is_u && !le && ucnt_ff < UW'(MAX_U_RUN)) || (hx && !le)) adv = 1'b1;
            else                                                          fail = 1'b1;
         end
         PH_DIGITS: begin
            if (hx && dcnt_ff == 2'd3) esc_done = 1'b1;
            else if (hx && !le)        adv = 1'b1;
            else                       fail = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign plain    = !adv && !esc_done;
   assign odd_mid  = (phase_ff == PH_URUN || phase_ff == PH_DIGITS) ? 1'b0 : odd_ff;
   assign open_esc = plain && is_bs && !odd_mid && !le;
   assign tail_any = esc_done || (plain && !open_esc);

   // next state
   always_comb begin
      odd_in   = odd_mid;
      phase_in = phase_ff;
      ucnt_in  = ucnt_ff;
      dcnt_in  = dcnt_ff;
      wr_en    = 1'b0;
      wr_idx   = dcnt_ff;
      if (adv) begin
         unique case (phase_ff)
            PH_SLASH: begin
               phase_in = PH_URUN;
               ucnt_in  = UW'(1);
            end
            PH_URUN: begin
               if (is_u) begin
                  ucnt_in = ucnt_ff + UW'(1);
               end else begin
                  phase_in = PH_DIGITS;
                  dcnt_in  = 2'd1;
                  wr_en    = 1'b1;
                  wr_idx   = 2'd0;
               end
            end
            PH_DIGITS: begin
               wr_en   = 1'b1;
               dcnt_in = dcnt_ff + 2'd1;
            end
            default: begin
            end
         endcase
      end else begin
         phase_in = PH_IDLE;
         ucnt_in  = '0;
         dcnt_in  = '0;
      end
      if (plain) begin
         if (is_bs) odd_in = !odd_mid;
         else       odd_in = 1'b0;
         if (open_esc) phase_in = PH_SLASH;
      end
      if (le) begin
         odd_in   = 1'b0;
         phase_in = PH_IDLE;
         ucnt_in  = '0;
         dcnt_in  = '0;
      end
   end

   // result list of the byte
   always_comb begin
      if (esc_done) begin
         new_val = {hex_nib(held_ff[0]), hex_nib(held_ff[1]), hex_nib(held_ff[2]),
                    hex_nib(b)};
      end else begin
         new_val = {8'h00, b};
      end
      new_cnt = CW'(tail_any);
      if (fail) new_cnt = new_cnt + CW'(1) + CW'(ucnt_ff) + CW'(dcnt_ff);
      new_last = new_cnt - CW'(1);
   end

   // pick the beat at the current job position
   always_comb begin
      off       = idx_ff - CW'(job_u_ff) - CW'(1);
      item_esc  = 1'b0;
      item_unit = job_val_ff;
      if (job_rep_ff && idx_ff == '0) begin
         item_unit = {8'h00, CH_BACKSLASH};
      end else if (job_rep_ff && idx_ff <= CW'(job_u_ff)) begin
         item_unit = {8'h00, CH_U};
      end else if (job_rep_ff && idx_ff <= CW'(job_u_ff) + CW'(job_d_ff)) begin
         item_unit = {8'h00, job_dig_ff[off[1:0]]};
      end else begin
         item_esc = job_esc_ff;
      end
   end

   assign item_last = (idx_ff == job_last_ff);
   assign out_load  = job_vld_ff && (!rsp_vld_ff || rsp.ready);
   assign req.ready = !job_vld_ff || (out_load && item_last);
   assign req_acc   = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff     <= 1'b0;
         phase_ff   <= PH_IDLE;
         ucnt_ff    <= '0;
         dcnt_ff    <= '0;
         job_vld_ff <= 1'b0;
         idx_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            odd_ff     <= odd_in;
            phase_ff   <= phase_in;
            ucnt_ff    <= ucnt_in;
            dcnt_ff    <= dcnt_in;
            job_vld_ff <= fail || tail_any;
            idx_ff     <= '0;
         end else if (out_load) begin
            if (item_last) job_vld_ff <= 1'b0;
            idx_ff <= idx_ff + CW'(1);
         end
         if (out_load)       rsp_vld_ff <= 1'b1;
         else if (rsp.ready) rsp_vld_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc && wr_en) held_ff[wr_idx] <= b;
      if (req_acc) begin
         job_rep_ff  <= fail;
         job_u_ff    <= ucnt_ff;
         job_d_ff    <= dcnt_ff;
         job_dig_ff  <= held_ff;
         job_val_ff  <= new_val;
         job_esc_ff  <= esc_done;
         job_le_ff   <= le;
         job_last_ff <= new_last;
      end
      if (out_load) begin
         rsp_unit_ff <= item_unit;
         rsp_esc_ff  <= item_esc;
         rsp_le_ff   <= job_le_ff && item_last;
         rsp_last_ff <= item_last;
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.code_unit   = rsp_unit_ff;
   assign rsp.from_escape = rsp_esc_ff;
   assign rsp.ends_line   = rsp_le_ff;
   assign rsp.last_of_run = rsp_last_ff;

endmodule
